// File: rtl/core/actr_pkg.sv
// Shared types, constants and functions for the AES-128 counter-mode engine.
package actr_pkg;

   localparam int COUNTER_BITS = 32;
   localparam int AES_ROUNDS = 10;
   localparam int BLOCK_BYTES = 16;
   localparam int BLOCK_BITS = 128;
   localparam int ROUND_BITS = 4;
   localparam int COUNT_BITS = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      KS_IDLE,
      KS_RUN
   } key_state_type;

   localparam logic [0:0] REG_KEY_VALUE = 1'b0;
   localparam logic [0:0] REG_FILE_ID = 1'b1;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] tbl [0:255];
      tbl = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return tbl[a];
   endfunction

   function automatic logic [7:0] rcon(input logic [ROUND_BITS-1:0] r);
      logic [7:0] v;
      case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1b;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of the state sits in bits 8i+7:8i.
   function automatic logic [BLOCK_BITS-1:0] aes_round(input logic [BLOCK_BITS-1:0] s,
                                                      input logic last);
      logic [BLOCK_BITS-1:0] t;
      logic [BLOCK_BITS-1:0] u;
      logic [BLOCK_BITS-1:0] m;
      logic [7:0] a0, a1, a2, a3, all;
      for (int i = 0; i < 16; i++) begin
         t[8*i +: 8] = sbox(s[8*i +: 8]);
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            u[8*(i + 4*c) +: 8] = t[8*(i + 4*((c + i) % 4)) +: 8];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = u[8*(4*c) +: 8];
         a1 = u[8*(4*c+1) +: 8];
         a2 = u[8*(4*c+2) +: 8];
         a3 = u[8*(4*c+3) +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[8*(4*c) +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return last ? u : m;
   endfunction

   // One step of the key schedule: round key r from round key r-1.
   function automatic logic [BLOCK_BITS-1:0] next_round_key(input logic [BLOCK_BITS-1:0] k,
                                                           input logic [ROUND_BITS-1:0] r);
      logic [31:0] t;
      logic [BLOCK_BITS-1:0] n;
      t[7:0] = sbox(k[111:104]) ^ rcon(r);
      t[15:8] = sbox(k[119:112]);
      t[23:16] = sbox(k[127:120]);
      t[31:24] = sbox(k[103:96]);
      n[31:0] = k[31:0] ^ t;
      n[63:32] = k[63:32] ^ n[31:0];
      n[95:64] = k[95:64] ^ n[63:32];
      n[127:96] = k[127:96] ^ n[95:64];
      return n;
   endfunction

endpackage

// File: rtl/core/actr_if.sv
// Valid/ready channel interfaces for the request, response and register write ports.
interface actr_req_if (input logic clock);
   logic valid;
   logic ready;
   logic [63:0] data_low;
   logic [63:0] data_high;
   logic [4:0] byte_count;
   logic first_block;
   modport source (output valid, data_low, data_high, byte_count, first_block, input ready);
   modport sink (input valid, data_low, data_high, byte_count, first_block, output ready);
endinterface

interface actr_rsp_if (input logic clock);
   logic valid;
   logic ready;
   logic [63:0] result_low;
   logic [63:0] result_high;
   logic [4:0] result_count;
   modport source (output valid, result_low, result_high, result_count, input ready);
   modport sink (input valid, result_low, result_high, result_count, output ready);
endinterface

interface actr_csr_if (input logic clock);
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/aes128_ctr_keystream_xor.sv
// Top level of the AES-128 counter-mode keystream engine.
//
//   channel   direction   payload
//   req       in          data_low, data_high, byte_count, first_block
//   rsp       out         result_low, result_high, result_count
//   csr       in          index (0 key_value, 1 file_id), data
//
// A request passes from acceptance through the initial key addition and ten rounds in a
// single shared round unit, then the final XOR in ST_DONE, before response valid.
// After a key write the key schedule unit writes 11 round keys, one per cycle, while
// req and csr are held not ready; reset starts the same expansion for the zero key.
// csr is also not ready while a request is in the rounds or the final XOR.
// The response waits in its register until taken; the next request is accepted from
// the cycle after that.
module aes128_ctr_keystream_xor (
   input logic clock,
   input logic reset,
   actr_req_if.sink req,
   actr_rsp_if.source rsp,
   actr_csr_if.sink csr
);

   actr_pkg::state_type state_ff, state_in;
   actr_pkg::key_state_type kstate_ff, kstate_in;
   logic [actr_pkg::ROUND_BITS-1:0] round_ff, round_in;
   logic [actr_pkg::ROUND_BITS-1:0] kround_ff, kround_in;
   logic [actr_pkg::BLOCK_BITS-1:0] state_data_ff, state_data_in;
   logic [actr_pkg::BLOCK_BITS-1:0] kreg_ff, kreg_in;
   logic [actr_pkg::BLOCK_BITS-1:0] rk_mem [0:actr_pkg::AES_ROUNDS];
   logic [actr_pkg::BLOCK_BITS-1:0] rk_rd_ff;
   logic [actr_pkg::ROUND_BITS-1:0] rk_raddr;
   logic rk_we;
   logic [actr_pkg::ROUND_BITS-1:0] rk_waddr;
   logic [actr_pkg::BLOCK_BITS-1:0] rk_wdata;
   logic [actr_pkg::COUNTER_BITS-1:0] counter_ff, counter_in;
   logic [31:0] file_id_ff, file_id_in;
   logic [127:0] data_ff, data_in;
   logic [4:0] count_ff, count_in;
   logic [63:0] rlow_ff, rlow_in, rhigh_ff, rhigh_in;
   logic [4:0] rcount_ff, rcount_in;
   logic rvalid_ff, rvalid_in;
   logic req_fire, csr_fire;
   logic [actr_pkg::BLOCK_BITS-1:0] round_out;
   logic [actr_pkg::BLOCK_BITS-1:0] ctr_block;
   logic [actr_pkg::BLOCK_BITS-1:0] ks;
   logic [127:0] xored;
   logic [4:0] sat_count;

   assign csr.ready = (kstate_ff == actr_pkg::KS_IDLE) && (state_ff == actr_pkg::ST_IDLE);
   assign csr_fire = csr.valid && csr.ready;
   assign req.ready = (state_ff == actr_pkg::ST_IDLE) && !rvalid_ff &&
                      (kstate_ff == actr_pkg::KS_IDLE);
   assign req_fire = req.valid && req.ready;
   assign rsp.valid = rvalid_ff;
   assign rsp.result_low = rlow_ff;
   assign rsp.result_high = rhigh_ff;
   assign rsp.result_count = rcount_ff;

   assign sat_count = (req.byte_count > 5'd16) ? 5'd16 : req.byte_count;

   always_comb begin
      ctr_block = '0;
      ctr_block[31:0] = 32'(req.first_block ? '0 : counter_ff);
      ctr_block[95:64] = file_id_ff;
   end

   assign round_out = actr_pkg::aes_round(state_data_ff, round_ff == 4'(actr_pkg::AES_ROUNDS));
   assign ks = state_data_ff;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         xored[8*i +: 8] = (5'(i) < count_ff) ? (data_ff[8*i +: 8] ^ ks[8*i +: 8]) : 8'h00;
      end
   end

   // Round key memory: one write port for the schedule, one registered read port.
   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_mem[rk_waddr] <= rk_wdata;
      end
      rk_rd_ff <= rk_mem[rk_raddr];
   end

   // Key schedule sequencer.
   always_comb begin
      kstate_in = kstate_ff;
      kround_in = kround_ff;
      kreg_in = kreg_ff;
      rk_we = 1'b0;
      rk_waddr = kround_ff;
      rk_wdata = kreg_ff;
      case (kstate_ff)
         actr_pkg::KS_IDLE: begin
            if (csr_fire && csr.index == actr_pkg::REG_KEY_VALUE) begin
               kreg_in = {64'h0, csr.data};
               kround_in = '0;
               kstate_in = actr_pkg::KS_RUN;
            end
         end
         actr_pkg::KS_RUN: begin
            rk_we = 1'b1;
            kreg_in = actr_pkg::next_round_key(kreg_ff, kround_ff + 4'd1);
            kround_in = kround_ff + 4'd1;
            if (kround_ff == 4'(actr_pkg::AES_ROUNDS)) begin
               kstate_in = actr_pkg::KS_IDLE;
            end
         end
         default: kstate_in = actr_pkg::KS_IDLE;
      endcase
   end

   // Datapath sequencer. The read address runs one round ahead of the state.
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      state_data_in = state_data_ff;
      counter_in = counter_ff;
      data_in = data_ff;
      count_in = count_ff;
      rlow_in = rlow_ff;
      rhigh_in = rhigh_ff;
      rcount_in = rcount_ff;
      rvalid_in = rvalid_ff;
      rk_raddr = '0;
      file_id_in = file_id_ff;
      if (csr_fire && csr.index == actr_pkg::REG_FILE_ID) begin
         file_id_in = csr.data[31:0];
      end
      if (rvalid_ff && rsp.ready) begin
         rvalid_in = 1'b0;
      end
      case (state_ff)
         actr_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_data_in = ctr_block;
               counter_in = (req.first_block ? '0 : counter_ff) + 1'b1;
               data_in = {req.data_high, req.data_low};
               count_in = sat_count;
               round_in = '0;
               state_in = actr_pkg::ST_ROUND;
            end
         end
         actr_pkg::ST_ROUND: begin
            rk_raddr = round_ff + 4'd1;
            round_in = round_ff + 4'd1;
            if (round_ff == '0) begin
               state_data_in = state_data_ff ^ rk_rd_ff;
            end else begin
               state_data_in = round_out ^ rk_rd_ff;
            end
            if (round_ff == 4'(actr_pkg::AES_ROUNDS)) begin
               state_in = actr_pkg::ST_DONE;
            end
         end
         actr_pkg::ST_DONE: begin
            rlow_in = xored[63:0];
            rhigh_in = xored[127:64];
            rcount_in = count_ff;
            rvalid_in = 1'b1;
            state_in = actr_pkg::ST_IDLE;
         end
         default: state_in = actr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= actr_pkg::ST_IDLE;
         kstate_ff <= actr_pkg::KS_RUN;
         kround_ff <= '0;
         kreg_ff <= '0;
         round_ff <= '0;
         counter_ff <= '0;
         file_id_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kstate_ff <= kstate_in;
         kround_ff <= kround_in;
         kreg_ff <= kreg_in;
         round_ff <= round_in;
         counter_ff <= counter_in;
         file_id_ff <= file_id_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      state_data_ff <= state_data_in;
      data_ff <= data_in;
      count_ff <= count_in;
      rlow_ff <= rlow_in;
      rhigh_ff <= rhigh_in;
      rcount_ff <= rcount_in;
   end

endmodule

// File: rtl/core/actr_checker.sv
// Port-level checks for the counter-mode engine, bound to the top level.
module actr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [4:0] rsp_result_count,
   input logic [63:0] rsp_result_high
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_count <= 5'd16)
      else $error("result count above sixteen");

   a_no_ready_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response waits");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("engine not busy after request");

   a_short_high_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_count <= 5'd8 |-> rsp_result_high == 64'h0)
      else $error("bytes beyond count not zero");

endmodule

bind aes128_ctr_keystream_xor actr_checker u_actr_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_result_count(rsp.result_count),
   .rsp_result_high(rsp.result_high)
);

// File: tb/testbench.sv
// Self-checking regression for the AES-128 counter-mode keystream engine.
module testbench;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0] cnt;
   } block_type;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0] cnt;
      logic first;
      logic has_exp;
      logic [63:0] exp_lo;
      logic [63:0] exp_hi;
      logic [4:0] exp_cnt;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int errors = 0;
   int cycles = 0;
   int sent = 0;
   int got = 0;
   int key_writes = 0;
   int hold_len = 0;

   actr_req_if req (clock);
   actr_rsp_if rsp (clock);
   actr_csr_if csr (clock);

   aes128_ctr_keystream_xor u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always #10 clock = ~clock;

   // Predictor state.
   logic [63:0] cur_key = '0;
   logic [31:0] cur_file = '0;
   logic [31:0] blk_ctr = '0;
   logic [7:0] sb [0:255];
   block_type pending [$];

   initial begin
      sb = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
   end

   function automatic logic [7:0] gmul2(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Encrypts the counter block under the current key; byte i in bits 8i+7:8i.
   function automatic logic [127:0] keystream(input logic [31:0] ctr);
      logic [7:0] w [0:175];
      logic [7:0] s [0:15];
      logic [7:0] t [0:15];
      logic [7:0] tw [0:3];
      logic [7:0] rc [0:10];
      logic [7:0] f, a0, a1, a2, a3, all;
      logic [127:0] res;
      rc = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      for (int i = 0; i < 16; i++) w[i] = (i < 8) ? cur_key[8*i +: 8] : 8'h00;
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) tw[j] = w[4*(i-1)+j];
         if (i % 4 == 0) begin
            f = tw[0];
            tw[0] = sb[tw[1]] ^ rc[i/4];
            tw[1] = sb[tw[2]];
            tw[2] = sb[tw[3]];
            tw[3] = sb[f];
         end
         for (int j = 0; j < 4; j++) w[4*i+j] = w[4*(i-4)+j] ^ tw[j];
      end
      for (int i = 0; i < 16; i++) s[i] = 8'h00;
      for (int i = 0; i < 4; i++) begin
         s[i] = ctr[8*i +: 8];
         s[8+i] = cur_file[8*i +: 8];
      end
      for (int i = 0; i < 16; i++) s[i] ^= w[i];
      for (int r = 1; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) t[i] = sb[s[i]];
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) s[i+4*c] = t[i+4*((c+i)%4)];
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               s[4*c] = a0 ^ all ^ gmul2(a0 ^ a1);
               s[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
               s[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
               s[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= w[16*r+i];
      end
      for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
      return res;
   endfunction

   function automatic block_type xor_block(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [4:0] cnt, input logic first);
      block_type b;
      logic [127:0] ks;
      logic [127:0] d;
      int n;
      n = (cnt > 16) ? 16 : cnt;
      if (first) blk_ctr = '0;
      ks = keystream(blk_ctr);
      d = {hi, lo} ^ ks;
      for (int i = n; i < 16; i++) d[8*i +: 8] = 8'h00;
      blk_ctr = blk_ctr + 32'd1;
      b.lo = d[63:0];
      b.hi = d[127:64];
      b.cnt = n[4:0];
      return b;
   endfunction

   task automatic report(input string what, input logic [63:0] seen, input logic [63:0] want);
      $display("mismatch on %s at response %0d: got %h, expected %h", what, got, seen, want);
      errors++;
   endtask

   task automatic wait_cycles(input int n);
      repeat (n) @(negedge clock);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [63:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      @(negedge clock);
      csr.valid <= 1'b0;
      if (idx == actr_pkg::REG_KEY_VALUE) begin
         cur_key = val;
         key_writes++;
      end else begin
         cur_file = val[31:0];
      end
      @(negedge clock);
   endtask

   // Queues the prediction when the request is accepted. Valid stays high after a
   // request so that a following one can go back to back; drain drops it.
   task automatic send(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] cnt,
                       input logic first, input bit gaps);
      int n;
      n = gaps ? $urandom_range(0, 13) : 0;
      if (n > 0) begin
         req.valid <= 1'b0;
         wait_cycles(n);
      end
      req.valid <= 1'b1;
      req.data_low <= lo;
      req.data_high <= hi;
      req.byte_count <= cnt;
      req.first_block <= first;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending.push_back(xor_block(lo, hi, cnt, first));
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      wait_cycles(30);
   endtask

   function automatic logic [63:0] rnd64();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0: v = '0;
         1: v = '1;
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Response side: a random wait before each response and one long hold-off.
   initial begin
      int n;
      rsp.ready = 1'b0;
      @(negedge clock);
      while (1) begin
         n = $urandom_range(0, 13);
         if (hold_len > 0) begin
            n = hold_len;
            hold_len = 0;
         end
         if (n > 0) begin
            rsp.ready <= 1'b0;
            wait_cycles(n);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp.valid && rsp.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      block_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending.size() == 0) begin
            report("unexpected response", rsp.result_low, '0);
         end else begin
            e = pending.pop_front();
            if (rsp.result_low !== e.lo) report("result_low", rsp.result_low, e.lo);
            if (rsp.result_high !== e.hi) report("result_high", rsp.result_high, e.hi);
            if (rsp.result_count !== e.cnt)
               report("result_count", 64'(rsp.result_count), 64'(e.cnt));
         end
         got++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("timeout after %0d cycles, %0d responses still pending", cycles, pending.size());
         $display("aes128_ctr_keystream_xor regression: fail");
         $finish;
      end
   end

   row_type rows [$];

   task automatic add_row(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] cnt,
                          input logic first, input logic has, input logic [63:0] elo,
                          input logic [63:0] ehi, input logic [4:0] ecnt);
      row_type r;
      r.lo = lo; r.hi = hi; r.cnt = cnt; r.first = first; r.has_exp = has;
      r.exp_lo = elo; r.exp_hi = ehi; r.exp_cnt = ecnt;
      rows.push_back(r);
   endtask

   initial begin
      block_type b;
      int len;
      req.valid = 1'b0;
      req.data_low = '0;
      req.data_high = '0;
      req.byte_count = '0;
      req.first_block = 1'b0;
      csr.valid = 1'b0;
      csr.index = actr_pkg::REG_KEY_VALUE;
      csr.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero count gives an all-zero response; the counter still moves.
      add_row('1, '1, 5'd0, 1'b1, 1'b1, '0, '0, 5'd0);
      add_row('0, '0, 5'd16, 1'b0, 1'b0, '0, '0, 5'd0);
      add_row('1, '1, 5'd16, 1'b0, 1'b0, '0, '0, 5'd0);
      add_row('1, '1, 5'd31, 1'b0, 1'b0, '0, '0, 5'd0);
      add_row('1, '1, 5'd17, 1'b1, 1'b0, '0, '0, 5'd0);
      add_row('1, '1, 5'd1, 1'b0, 1'b0, '0, '0, 5'd0);
      add_row('1, '1, 5'd8, 1'b0, 1'b0, '0, '0, 5'd0);
      add_row('1, '1, 5'd9, 1'b0, 1'b0, '0, '0, 5'd0);
      add_row(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b0, 1'b0, '0, '0, 5'd0);
      add_row('0, '1, 5'd0, 1'b0, 1'b1, '0, '0, 5'd0);
      add_row('1, '0, 5'd16, 1'b1, 1'b0, '0, '0, 5'd0);
      add_row('1, '1, 5'd4, 1'b0, 1'b0, '0, '0, 5'd0);

      foreach (rows[i]) begin
         if (rows[i].has_exp) begin
            // The typed-in value must agree with the predictor before use.
            b = xor_block(rows[i].lo, rows[i].hi, rows[i].cnt, rows[i].first);
            if (b.lo !== rows[i].exp_lo || b.hi !== rows[i].exp_hi || b.cnt !== rows[i].exp_cnt)
               report("directed table row", b.lo, rows[i].exp_lo);
            blk_ctr = blk_ctr - 32'd1;
         end
         send(rows[i].lo, rows[i].hi, rows[i].cnt, rows[i].first, (i % 2) == 1);
      end
      drain();

      // Extreme settings: all-ones key and file id.
      csr_write(actr_pkg::REG_KEY_VALUE, '1);
      csr_write(actr_pkg::REG_FILE_ID, '1);
      for (int i = 0; i < 6; i++) send('1, '0, 5'd16, i == 0, 1);
      drain();
      csr_write(actr_pkg::REG_KEY_VALUE, 64'h8000000000000001);
      csr_write(actr_pkg::REG_FILE_ID, 64'h0);

      // Sender keeps offering while the receiver holds off.
      hold_len = 300;
      for (int i = 0; i < 8; i++) send(rnd64(), rnd64(), 5'd16, 1'b0, 0);
      drain();

      // Streams: a first block, full blocks, maybe a short last one; now and then a random request.
      while (sent < 520) begin
         if ($urandom_range(0, 9) == 0) begin
            drain();
            if ($urandom_range(0, 1)) csr_write(actr_pkg::REG_KEY_VALUE, rnd64());
            else csr_write(actr_pkg::REG_FILE_ID, rnd64());
         end
         len = $urandom_range(1, 12);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0)
               send(rnd64(), rnd64(), 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1);
            else
               send(rnd64(), rnd64(), (k == len - 1) ? 5'($urandom_range(1, 16)) : 5'd16,
                    k == 0, 1'($urandom_range(0, 1)));
         end
      end
      drain();

      $display("sent %0d requests, checked %0d responses, %0d key writes",
               sent, got, key_writes);
      $display("covered short, zero and oversized counts, restarts and back-pressure");
      if (errors == 0) begin
         $display("aes128_ctr_keystream_xor regression: pass");
      end else begin
         $display("aes128_ctr_keystream_xor regression: fail");
      end
      $finish;
   end

endmodule

// File: aes128_ctr_keystream_xor.f
rtl/core/actr_pkg.sv
rtl/core/actr_if.sv
rtl/core/aes128_ctr_keystream_xor.sv
rtl/core/actr_checker.sv
tb/testbench.sv
